// File: sv/cbz_pkg.sv
// ----------------------------------------------------------------------------
// cbz_pkg: shared types and constants of the color box zone detector
// Register indexes, result codes, the pixel and result words, and the
// reciprocal used to split the frame width into thirds.
// ----------------------------------------------------------------------------
package cbz_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd4;

    localparam int unsigned DIM_CFG_W = 11;
    localparam int unsigned COLOR_W   = 24;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST     = 11'd640;
    localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST    = 11'd480;
    localparam logic [COLOR_W-1:0]   COLOR_LOW_RST       = 24'h000000;
    localparam logic [COLOR_W-1:0]   COLOR_HIGH_RST      = 24'hFFFFFF;
    localparam logic [CNT_W-1:0]     COUNT_THRESHOLD_RST = 21'd38400;

    // floor(x / 3) == (x * THIRD_MUL) >> THIRD_SHIFT for every x below 2^17
    localparam logic [31:0] THIRD_MUL   = 32'd43691;
    localparam int unsigned THIRD_SHIFT = 17;

    // Direction codes
    localparam logic [1:0] DIR_MIDDLE = 2'd0;
    localparam logic [1:0] DIR_LEFT   = 2'd1;
    localparam logic [1:0] DIR_RIGHT  = 2'd2;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] frame_width;
        logic [DIM_CFG_W-1:0] frame_height;
        logic [COLOR_W-1:0]   color_low;
        logic [COLOR_W-1:0]   color_high;
        logic [CNT_W-1:0]     count_threshold;
    } cbz_cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cbz_pixel_t;

    typedef struct packed {
        logic [1:0] direction;
        logic       obstacle;
        logic       frame_end;
        logic       selected;
    } cbz_result_t;

endpackage

// File: sv/cbz_config.sv
// ----------------------------------------------------------------------------
// cbz_config: configuration register file
// Holds frame size, color box bounds and the count threshold; write only.
// ----------------------------------------------------------------------------
module cbz_config
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbz_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output cbz_pkg::cbz_cfg_t                cfg
);
    import cbz_pkg::*;

    cbz_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= FRAME_WIDTH_RST;
            cfg_reg.frame_height    <= FRAME_HEIGHT_RST;
            cfg_reg.color_low       <= COLOR_LOW_RST;
            cfg_reg.color_high      <= COLOR_HIGH_RST;
            cfg_reg.count_threshold <= COUNT_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_wdata[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_wdata[DIM_CFG_W-1:0];
                REG_COLOR_LOW:       cfg_reg.color_low       <= cfg_wdata[COLOR_W-1:0];
                REG_COLOR_HIGH:      cfg_reg.color_high      <= cfg_wdata[COLOR_W-1:0];
                REG_COUNT_THRESHOLD: cfg_reg.count_threshold <= cfg_wdata[CNT_W-1:0];
                default:             ; // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/cbz_stats.sv
// ----------------------------------------------------------------------------
// cbz_stats: raster position, color box test and zone counters
// Classify the pixel in the input register and update counts on each step.
// ----------------------------------------------------------------------------
module cbz_stats
#(
    parameter int unsigned MAX_WIDTH    = 1024,
    parameter int unsigned MAX_HEIGHT   = 1024,
    parameter int unsigned BORDER_WIDTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbz_pkg::cbz_cfg_t     cfg,
    input  cbz_pkg::cbz_pixel_t   pixel,
    input  logic                  step,
    output cbz_pkg::cbz_result_t  result
);
    import cbz_pkg::*;

    localparam int unsigned PW = $clog2(MAX_WIDTH);      // column index
    localparam int unsigned RW = $clog2(MAX_HEIGHT);     // row index
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);  // effective width
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1); // effective height
    localparam int unsigned SW = WW + 1;
    localparam int unsigned SH = HW + 1;

    // Geometry derived from configuration, registered after the configuration registers
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [WW-1:0] third_reg, third_next;
    logic [WW-1:0] two_third_reg, two_third_next;
    logic [31:0]   third_prod, two_third_prod;

    logic [PW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] middle_reg, middle_next;
    logic [CNT_W-1:0] right_reg, right_next;

    logic [SW-1:0] col_inc, col_far;
    logic [SH-1:0] row_inc, row_far;
    logic          row_end, frame_end, border, sel;
    logic          in_left, in_right;
    cbz_pixel_t    pix;

    always_comb
    begin
        if (cfg.frame_width == '0)
            width_next = WW'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            width_next = WW'(MAX_WIDTH);
        else
            width_next = WW'(cfg.frame_width);

        if (cfg.frame_height == '0)
            height_next = HW'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
            height_next = HW'(MAX_HEIGHT);
        else
            height_next = HW'(cfg.frame_height);

        third_prod     = 32'(width_next) * THIRD_MUL;
        two_third_prod = (32'(width_next) << 1) * THIRD_MUL;
        third_next     = WW'(third_prod >> THIRD_SHIFT);
        two_third_next = WW'(two_third_prod >> THIRD_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        height_reg    <= height_next;
        third_reg     <= third_next;
        two_third_reg <= two_third_next;
    end

    always_comb
    begin
        col_inc   = SW'(col_reg) + SW'(1);
        row_inc   = SH'(row_reg) + SH'(1);
        col_far   = SW'(col_reg) + SW'(BORDER_WIDTH);
        row_far   = SH'(row_reg) + SH'(BORDER_WIDTH);
        row_end   = (col_inc >= SW'(width_reg));
        frame_end = row_end && (row_inc >= SH'(height_reg));

        border = (32'(col_reg) < 32'(BORDER_WIDTH)) || (32'(row_reg) < 32'(BORDER_WIDTH)) ||
                 (col_far >= SW'(width_reg)) || (row_far >= SH'(height_reg));

        pix = border ? '0 : pixel;
        sel = (pix.red   >= cfg.color_low[23:16]) && (pix.red   <= cfg.color_high[23:16]) &&
              (pix.green >= cfg.color_low[15:8])  && (pix.green <= cfg.color_high[15:8])  &&
              (pix.blue  >= cfg.color_low[7:0])   && (pix.blue  <= cfg.color_high[7:0]);

        in_left  = (WW'(col_reg) > two_third_reg);
        in_right = (WW'(col_reg) < third_reg);

        total_next  = total_reg;
        left_next   = left_reg;
        middle_next = middle_reg;
        right_next  = right_reg;
        if (sel)
        begin
            if (total_reg != CNT_MAX)
                total_next = total_reg + CNT_W'(1);
            if (in_left)
            begin
                if (left_reg != CNT_MAX)
                    left_next = left_reg + CNT_W'(1);
            end
            else if (in_right)
            begin
                if (right_reg != CNT_MAX)
                    right_next = right_reg + CNT_W'(1);
            end
            else if (middle_reg != CNT_MAX)
            begin
                middle_next = middle_reg + CNT_W'(1);
            end
        end

        result.selected  = sel;
        result.frame_end = frame_end;
        result.obstacle  = 1'b0;
        result.direction = DIR_MIDDLE;
        if (frame_end)
        begin
            result.obstacle = (total_next > cfg.count_threshold);
            if ((middle_next > right_next) && (middle_next > left_next))
                result.direction = DIR_MIDDLE;
            else if (left_next > right_next)
                result.direction = DIR_LEFT;
            else
                result.direction = DIR_RIGHT;
        end

        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : RW'(row_inc);
        end
        else
        begin
            col_next = PW'(col_inc);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            total_reg  <= '0;
            left_reg   <= '0;
            middle_reg <= '0;
            right_reg  <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (frame_end)
            begin
                total_reg  <= '0;
                left_reg   <= '0;
                middle_reg <= '0;
                right_reg  <= '0;
            end
            else
            begin
                total_reg  <= total_next;
                left_reg   <= left_next;
                middle_reg <= middle_next;
                right_reg  <= right_next;
            end
        end
    end

endmodule

// File: sv/color_box_obstacle_zone_detector_unit.sv
// ----------------------------------------------------------------------------
// color_box_obstacle_zone_detector_unit: color box segmentation with zones
// Streams BGR pixels in raster order and reports selection per pixel plus an
// obstacle flag and a steering direction on the last pixel of each frame.
// ----------------------------------------------------------------------------
// One pixel word is taken every clock while the output side is not stalled,
// and one result word leaves per pixel, passing the input register and then
// the result register. Between the two, the color box test, the border mask
// and the zone counter update run combinationally; with the output side not
// stalled, the single counter update per pixel sets the throughput of one
// pixel per clock. The block tracks row and column itself: frame_width and
// frame_height (0 reads as 1, values above the maximum saturate) define the
// raster, and pixels within BORDER_WIDTH of any edge test as black. Column
// zones: above floor(2W/3) is left, below floor(W/3) is right, the rest is
// middle. On the last pixel (tlast high) the result carries obstacle =
// selected total > count_threshold and the zone with the most selected
// pixels, after which all counts clear. Write configuration only while no
// pixel is in flight; the width thirds take up a register write in the next cycle.
// ----------------------------------------------------------------------------
module color_box_obstacle_zone_detector_unit
#(
    parameter int unsigned MAX_WIDTH    = 1024,
    parameter int unsigned MAX_HEIGHT   = 1024,
    parameter int unsigned BORDER_WIDTH = 2
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [cbz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbz_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // blue, green, red

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // selected, obstacle,
                                                            // direction[1:0], zero pad
    output logic                             m_axis_tlast   // frame_end
);
    import cbz_pkg::*;

    cbz_cfg_t    cfg;
    cbz_pixel_t  pix_reg;
    logic        in_valid_reg;
    cbz_result_t res_comb;
    cbz_result_t res_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        step;
    logic        accept;

    cbz_config u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbz_stats
    #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .BORDER_WIDTH (BORDER_WIDTH)
    )
    u_stats
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pixel  (pix_reg),
        .step   (step),
        .result (res_comb)
    );

    // Result register can take a new word when empty or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    // Input register frees up when empty or when its word moves on
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: hold while stalled, advance on handshake
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= s_axis_tdata;
        if (step)
            res_reg <= res_comb;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.frame_end;
    assign m_axis_tdata  = {4'b0000, res_reg.direction, res_reg.obstacle, res_reg.selected};

    // Obstacle and direction stay clear away from the frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[3:1] == 3'b000))
        else $error("obstacle or direction set on a word that is not frame end");

    // Direction code three is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:2] != 2'd3))
        else $error("invalid direction code");

    // A pixel moving out of the input register shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost between input and result register");

    // With both registers full and output stalled, no pixel is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("pixel accepted with no room in the pipeline");

endmodule
